// File: hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants shared by the one-wire bus master: beat payloads, the
// timing register set, register indexes, command codes, modes and phases.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // command codes carried in the operation field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // command modes held by the engine
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // slot phases
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_MIDDLE = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

    // timing register indexes
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_SMP  = 3'd1;
    localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [2:0] REG_SLOT_RECOVER  = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_READ_REST     = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIMER_W    = 10;
    localparam int READ_OUT_W = 16;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] write_byte;
        logic [4:0] read_count;
        logic       line_level;
    } owbm_in_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence_level;
        logic [15:0] read_data;
        logic        rejected;
    } owbm_out_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_sample_time;
        logic [9:0] reset_recover_time;
        logic [5:0] slot_low_time;
        logic [7:0] write_hold_time;
        logic [5:0] slot_recover_time;
        logic [5:0] read_sample_time;
        logic [7:0] read_rest_time;
    } owbm_cfg_t;

    // length in ticks of a phase; a zero register still gives one tick
    function automatic logic [TIMER_W-1:0] phase_len(
        input logic [1:0] mode,
        input logic [1:0] phase,
        input owbm_cfg_t  cfg
    );
        logic [TIMER_W-1:0] t;
        t = '0;
        if (mode == MODE_RESET) begin
            if (phase == PH_START)
                t = cfg.reset_low_time;
            else if (phase == PH_MIDDLE)
                t = cfg.presence_sample_time;
            else
                t = cfg.reset_recover_time;
        end else if (mode == MODE_WRITE) begin
            if (phase == PH_START)
                t = TIMER_W'(cfg.slot_low_time);
            else if (phase == PH_MIDDLE)
                t = TIMER_W'(cfg.write_hold_time);
            else
                t = TIMER_W'(cfg.slot_recover_time);
        end else begin
            if (phase == PH_START)
                t = TIMER_W'(cfg.slot_low_time);
            else if (phase == PH_MIDDLE)
                t = TIMER_W'(cfg.read_sample_time);
            else
                t = TIMER_W'(cfg.read_rest_time);
        end
        if (t == '0)
            t = TIMER_W'(1);
        return t;
    endfunction

endpackage

// File: hw/rtl/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Timing register file, written one register per configuration beat.
// ----------------------------------------------------------------------------
module owbm_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] wr_data,
    output owbm_pkg::owbm_cfg_t             cfg
);
    import owbm_pkg::*;

    owbm_cfg_t cfg_reg;
    owbm_cfg_t cfg_next;

    // pick the addressed field, truncating the data to its width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_RESET_LOW:     cfg_next.reset_low_time       = wr_data;
                REG_PRESENCE_SMP:  cfg_next.presence_sample_time = wr_data;
                REG_RESET_RECOVER: cfg_next.reset_recover_time   = wr_data;
                REG_SLOT_LOW:      cfg_next.slot_low_time        = wr_data[5:0];
                REG_WRITE_HOLD:    cfg_next.write_hold_time      = wr_data[7:0];
                REG_SLOT_RECOVER:  cfg_next.slot_recover_time    = wr_data[5:0];
                REG_READ_SAMPLE:   cfg_next.read_sample_time     = wr_data[5:0];
                REG_READ_REST:     cfg_next.read_rest_time       = wr_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // register file with the standard timings after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.reset_low_time       <= 10'd500;
            cfg_reg.presence_sample_time <= 10'd70;
            cfg_reg.reset_recover_time   <= 10'd430;
            cfg_reg.slot_low_time        <= 6'd2;
            cfg_reg.write_hold_time      <= 8'd55;
            cfg_reg.slot_recover_time    <= 6'd2;
            cfg_reg.read_sample_time     <= 6'd10;
            cfg_reg.read_rest_time       <= 8'd49;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine
// Bus state machine: one tick per step, computing the drive, status and
// read data of that tick and advancing the slot state.
// ----------------------------------------------------------------------------
module owbm_engine #(
    parameter int WRITE_BITS    = 8,
    parameter int MAX_READ_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  owbm_pkg::owbm_in_t   tick,
    input  owbm_pkg::owbm_cfg_t  cfg,
    output owbm_pkg::owbm_out_t  res
);
    import owbm_pkg::*;

    localparam int MAX_BITS = (WRITE_BITS > MAX_READ_BITS) ? WRITE_BITS : MAX_READ_BITS;
    localparam int BLW      = $clog2(MAX_BITS + 1);
    localparam int BPW      = $clog2(MAX_READ_BITS + 1);

    logic [1:0]            mode_reg,     mode_next;
    logic [1:0]            phase_reg,    phase_next;
    logic [TIMER_W-1:0]    timer_reg,    timer_next;
    logic [BLW-1:0]        bits_reg,     bits_next;
    logic [7:0]            send_reg,     send_next;
    logic [READ_OUT_W-1:0] rshift_reg,   rshift_next;
    logic [BPW-1:0]        bitpos_reg,   bitpos_next;
    logic                  presence_reg, presence_next;

    logic                  drive;
    logic                  done;
    logic                  rej;
    logic [READ_OUT_W-1:0] rdata;
    logic [BLW-1:0]        rcount;

    // one tick: command start, drive, then phase timer
    always_comb
    begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bits_next     = bits_reg;
        send_next     = send_reg;
        rshift_next   = rshift_reg;
        bitpos_next   = bitpos_reg;
        presence_next = presence_reg;
        drive         = 1'b0;
        done          = 1'b0;
        rej           = 1'b0;
        rdata         = '0;
        rcount        = (int'(tick.read_count) > MAX_READ_BITS) ?
                        BLW'(MAX_READ_BITS) : BLW'(tick.read_count);

        // command decode
        if (mode_reg != MODE_IDLE) begin
            rej = (tick.operation != OP_TICK);
        end else begin
            unique case (tick.operation)
                OP_RESET:
                begin
                    mode_next  = MODE_RESET;
                    phase_next = PH_START;
                    timer_next = phase_len(MODE_RESET, PH_START, cfg);
                end
                OP_WRITE:
                begin
                    mode_next  = MODE_WRITE;
                    send_next  = tick.write_byte;
                    bits_next  = BLW'(WRITE_BITS);
                    phase_next = PH_START;
                    timer_next = phase_len(MODE_WRITE, PH_START, cfg);
                end
                OP_READ:
                begin
                    rshift_next = '0;
                    bitpos_next = '0;
                    if (rcount == '0) begin
                        done = 1'b1;
                    end else begin
                        mode_next  = MODE_READ;
                        bits_next  = rcount;
                        phase_next = PH_START;
                        timer_next = phase_len(MODE_READ, PH_START, cfg);
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        // active command: drive and timer
        if (mode_next != MODE_IDLE) begin
            if (phase_next == PH_START)
                drive = 1'b1;
            else if (phase_next == PH_MIDDLE && mode_next == MODE_WRITE)
                drive = ~send_next[0];

            timer_next = timer_next - TIMER_W'(1);
            if (timer_next == '0) begin
                if (mode_next == MODE_RESET) begin
                    if (phase_next == PH_START) begin
                        phase_next = PH_MIDDLE;
                        timer_next = phase_len(MODE_RESET, PH_MIDDLE, cfg);
                    end else if (phase_next == PH_MIDDLE) begin
                        presence_next = tick.line_level;
                        phase_next    = PH_END;
                        timer_next    = phase_len(MODE_RESET, PH_END, cfg);
                    end else begin
                        mode_next  = MODE_IDLE;
                        phase_next = PH_START;
                        done       = 1'b1;
                    end
                end else if (phase_next != PH_END) begin
                    // read sample at the end of the middle phase
                    if (mode_next == MODE_READ && phase_next == PH_MIDDLE &&
                        tick.line_level) begin
                        for (int i = 0; i < READ_OUT_W; i++) begin
                            if (int'(bitpos_next) == i)
                                rshift_next[i] = 1'b1;
                        end
                    end
                    phase_next = phase_next + 2'd1;
                    timer_next = phase_len(mode_next, phase_next, cfg);
                end else begin
                    if (mode_next == MODE_WRITE)
                        send_next = send_next >> 1;
                    else
                        bitpos_next = bitpos_next + BPW'(1);
                    bits_next = bits_next - BLW'(1);
                    if (bits_next == '0) begin
                        if (mode_next == MODE_READ)
                            rdata = rshift_next;
                        mode_next  = MODE_IDLE;
                        phase_next = PH_START;
                        done       = 1'b1;
                    end else begin
                        phase_next = PH_START;
                        timer_next = phase_len(mode_next, PH_START, cfg);
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= MODE_IDLE;
            phase_reg    <= PH_START;
            timer_reg    <= '0;
            bits_reg     <= '0;
            send_reg     <= '0;
            rshift_reg   <= '0;
            bitpos_reg   <= '0;
            presence_reg <= 1'b1;
        end else if (step) begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bits_reg     <= bits_next;
            send_reg     <= send_next;
            rshift_reg   <= rshift_next;
            bitpos_reg   <= bitpos_next;
            presence_reg <= presence_next;
        end
    end

    assign res.drive_low      = drive;
    assign res.busy_res       = (mode_next != MODE_IDLE);
    assign res.done_res       = done;
    assign res.presence_level = presence_next;
    assign res.read_data      = rdata;
    assign res.rejected       = rej;

`ifndef SYNTHESIS
    // a command in progress always has a running phase timer
    a_timer_running: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_IDLE |-> timer_reg != '0)
        else $error("phase timer stopped during a command");

    // rejection only happens while a command is in progress
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && rej |-> mode_reg != MODE_IDLE)
        else $error("command rejected while idle");

    // a write command loads the full bit count on start
    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg == MODE_IDLE && tick.operation == OP_WRITE
        |=> mode_reg == MODE_WRITE && bits_reg == BLW'(WRITE_BITS))
        else $error("write command did not start correctly");
`endif

endmodule

// File: hw/rtl/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// One-wire bus master: one tick beat in, one result beat out, with reset and
// presence detect, byte write and multi-bit read under programmable timing.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item  (owbm_in_t)
//   res      output     res_valid/res_ready  res_item (owbm_out_t)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick beat per cycle sustained while res_ready stays high; a result goes
// from the input register through the engine into the result register, which
// offers it until res_ready takes it.
// The engine state advances as a tick moves into the result register, so the
// whole tick is worked in the same cycle as that move.
// Reset restores the standard timings and idles the bus; cfg_ready is always
// high. A stall on res_ready holds the result and then the input register.
// ----------------------------------------------------------------------------
module onewire_bus_master #(
    parameter int WRITE_BITS    = 8,
    parameter int MAX_READ_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  owbm_pkg::owbm_in_t              in_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output owbm_pkg::owbm_out_t             res_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owbm_pkg::*;

    owbm_cfg_t cfg;
    owbm_in_t  tick_reg;
    logic      tick_valid_reg;
    owbm_out_t res_reg;
    logic      res_valid_reg;
    owbm_out_t step_res;
    logic      advance;
    logic      res_free;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    owbm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipeline flow control
    assign res_free = !res_valid_reg || res_ready;
    assign advance  = tick_valid_reg && res_free;
    assign in_ready = !tick_valid_reg || advance;

    owbm_engine #(
        .WRITE_BITS    (WRITE_BITS),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .tick  (tick_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (in_ready)
            tick_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            tick_reg <= in_item;
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= tick_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_res;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

`ifndef SYNTHESIS
    // a completing command is no longer busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.done_res |-> !res_item.busy_res)
        else $error("done beat still reports busy");

    // read data only shows on a done beat
    a_data_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.read_data != '0 |-> res_item.done_res)
        else $error("read data outside a done beat");

    // the line is released whenever the bus is not busy
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.busy_res |-> !res_item.drive_low)
        else $error("line driven while not busy");
`endif

endmodule
